>>> rtl/core/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg: shared definitions of the interval timer
// Field widths, reset values, register codes and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tci_pkg;

	localparam int SampleW  = 8;
	localparam int CyclesW  = 24;
	localparam int SecondsW = 16;
	localparam int TicksW   = 8;
	localparam int AddrW    = 5;
	localparam int DataW    = 32;
	localparam int NumW     = 15;
	localparam int DivW     = 8;

	localparam int TICKS_PER_SECOND_DEF = 100;

	localparam int NominalTicks = 100;
	localparam int MinTicks     = 50;
	localparam int MaxTicks     = 200;
	localparam int FastGain     = 50;
	localparam int SlowGain     = 100;

	localparam logic [SampleW-1:0]  TEMP_LOW_RST         = 8'd84;
	localparam logic [SampleW-1:0]  TEMP_MID_RST         = 8'd107;
	localparam logic [SampleW-1:0]  TEMP_HIGH_RST        = 8'd141;
	localparam logic [CyclesW-1:0]  WAIT_CYCLE_COUNT_RST = 24'd43200;
	localparam logic [SecondsW-1:0] RELAY_SECONDS_RST    = 16'd240;

	localparam logic [2:0] REG_TEMP_LOW         = 3'd0;
	localparam logic [2:0] REG_TEMP_MID         = 3'd1;
	localparam logic [2:0] REG_TEMP_HIGH        = 3'd2;
	localparam logic [2:0] REG_WAIT_CYCLE_COUNT = 3'd3;
	localparam logic [2:0] REG_RELAY_SECONDS    = 3'd4;

	typedef struct packed {
		logic [SampleW-1:0]  temp_low;
		logic [SampleW-1:0]  temp_mid;
		logic [SampleW-1:0]  temp_high;
		logic [CyclesW-1:0]  wait_cycle_count;
		logic [SecondsW-1:0] relay_seconds;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_busy;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/core/tci_regs.sv
// ----------------------------------------------------------------------------
// tci_regs: configuration register file
// Holds thresholds and phase lengths, written and read over the APB port.
// ----------------------------------------------------------------------------
module tci_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tci_pkg::AddrW-1:0]   paddr,
	input  logic [tci_pkg::DataW-1:0]   pwdata,
	output logic [tci_pkg::DataW-1:0]   prdata,
	output logic                        pready,
	output tci_pkg::cfg_t               cfg
);

	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign idx    = paddr[tci_pkg::AddrW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.temp_low         <= tci_pkg::TEMP_LOW_RST;
			cfg.temp_mid         <= tci_pkg::TEMP_MID_RST;
			cfg.temp_high        <= tci_pkg::TEMP_HIGH_RST;
			cfg.wait_cycle_count <= tci_pkg::WAIT_CYCLE_COUNT_RST;
			cfg.relay_seconds    <= tci_pkg::RELAY_SECONDS_RST;
		end else if (wr) begin
			unique case (idx)
				tci_pkg::REG_TEMP_LOW: begin
					cfg.temp_low <= pwdata[tci_pkg::SampleW-1:0];
				end
				tci_pkg::REG_TEMP_MID: begin
					cfg.temp_mid <= pwdata[tci_pkg::SampleW-1:0];
				end
				tci_pkg::REG_TEMP_HIGH: begin
					cfg.temp_high <= pwdata[tci_pkg::SampleW-1:0];
				end
				tci_pkg::REG_WAIT_CYCLE_COUNT: begin
					cfg.wait_cycle_count <= pwdata[tci_pkg::CyclesW-1:0];
				end
				tci_pkg::REG_RELAY_SECONDS: begin
					cfg.relay_seconds <= pwdata[tci_pkg::SecondsW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tci_pkg::REG_TEMP_LOW:         prdata = tci_pkg::DataW'(cfg.temp_low);
			tci_pkg::REG_TEMP_MID:         prdata = tci_pkg::DataW'(cfg.temp_mid);
			tci_pkg::REG_TEMP_HIGH:        prdata = tci_pkg::DataW'(cfg.temp_high);
			tci_pkg::REG_WAIT_CYCLE_COUNT: prdata = tci_pkg::DataW'(cfg.wait_cycle_count);
			tci_pkg::REG_RELAY_SECONDS:    prdata = tci_pkg::DataW'(cfg.relay_seconds);
			default:                       prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/tci_div.sv
// ----------------------------------------------------------------------------
// tci_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module tci_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tci_pkg::NumW-1:0]   dividend,
	input  logic [tci_pkg::DivW-1:0]   divisor,
	output logic                       busy,
	output logic [tci_pkg::NumW-1:0]   quotient
);

	localparam int CntW = $clog2(tci_pkg::NumW + 1);

	logic [tci_pkg::DivW-1:0] rem_q;
	logic [tci_pkg::DivW-1:0] den_q;
	logic [tci_pkg::NumW-1:0] quo_q;
	logic [CntW-1:0]          cnt_q;
	logic                     busy_q;
	logic [tci_pkg::DivW:0]   trial;
	logic [tci_pkg::DivW:0]   diff;
	logic                     fits;
	logic [tci_pkg::DivW-1:0] rem_n;

	always_comb begin
		trial = {rem_q, quo_q[tci_pkg::NumW-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
		rem_n = fits ? diff[tci_pkg::DivW-1:0] : trial[tci_pkg::DivW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(tci_pkg::NumW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[tci_pkg::NumW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("divider busy with empty step count");

endmodule

>>> rtl/core/tci_dp.sv
// ----------------------------------------------------------------------------
// tci_dp: timer datapath
// Sample clamp, cycle length from the iterative divider, phase counters and
// the output register.
// ----------------------------------------------------------------------------
module tci_dp #(
	parameter int TICKS_PER_SECOND = tci_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tci_pkg::cfg_t                 cfg,
	input  logic [tci_pkg::SampleW-1:0]   adc_sample,
	input  tci_pkg::dp_cmd_t              cmd,
	output tci_pkg::dp_stat_t             stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          relay_on,
	output logic                          led_on,
	output logic                          cycle_end
);

	localparam int SubW = $clog2(TICKS_PER_SECOND + 1);
	localparam logic [SubW-1:0] SubLimit = SubW'(TICKS_PER_SECOND);
	localparam logic signed [16:0] TNom = 17'(tci_pkg::NominalTicks);
	localparam logic signed [16:0] TMin = 17'(tci_pkg::MinTicks);
	localparam logic signed [16:0] TMax = 17'(tci_pkg::MaxTicks);

	logic [tci_pkg::SampleW-1:0]  sample_q;
	logic                         relay_q;
	logic                         led_q;
	logic [tci_pkg::CyclesW-1:0]  cycles_q;
	logic [tci_pkg::TicksW-1:0]   ticks_q;
	logic [tci_pkg::SecondsW-1:0] seconds_q;
	logic [SubW-1:0]              subtick_q;
	logic                         out_valid_q;
	logic                         relay_on_q;
	logic                         led_on_q;
	logic                         cycle_end_q;

	logic signed [9:0]            s_ext, lo_ext, mid_ext, hi_ext, s_clamp, v, d, v_abs, d_abs;
	logic                         v_neg, d_neg, d_zero, q_neg;
	logic [tci_pkg::NumW-1:0]     num_mag;
	logic [tci_pkg::NumW-1:0]     q_mag;
	logic signed [16:0]           q_ext, t_div, t_sel;
	logic [tci_pkg::TicksW-1:0]   t_new;
	logic                         div_busy;

	logic                         ew_relay;
	logic                         n_relay, n_led, n_end;
	logic [tci_pkg::CyclesW-1:0]  n_cycles, c_dec;
	logic [tci_pkg::TicksW-1:0]   n_ticks, t_cur, t_dec;
	logic [tci_pkg::SecondsW-1:0] n_seconds, s_dec;
	logic [SubW-1:0]              n_subtick, st_inc;

	// cycle length
	always_comb begin
		s_ext   = $signed({2'b00, sample_q});
		lo_ext  = $signed({2'b00, cfg.temp_low});
		mid_ext = $signed({2'b00, cfg.temp_mid});
		hi_ext  = $signed({2'b00, cfg.temp_high});
		if (s_ext < lo_ext) begin
			s_clamp = lo_ext;
		end else if (s_ext > hi_ext) begin
			s_clamp = hi_ext;
		end else begin
			s_clamp = s_ext;
		end
		v      = s_clamp - mid_ext;
		v_neg  = v[9];
		d      = v_neg ? (mid_ext - lo_ext) : (hi_ext - mid_ext);
		d_neg  = d[9];
		d_zero = (d == '0);
		v_abs  = v_neg ? -v : v;
		d_abs  = d_neg ? -d : d;
		q_neg  = v_neg ^ d_neg;
		num_mag = tci_pkg::NumW'(v_abs[7:0]) *
			(v_neg ? tci_pkg::NumW'(tci_pkg::SlowGain) : tci_pkg::NumW'(tci_pkg::FastGain));
		q_ext = $signed({2'b00, q_mag});
		t_div = q_neg ? (TNom + q_ext) : (TNom - q_ext);
		if (d_zero) begin
			if (v_neg) begin
				t_sel = TMax;
			end else if (v == '0) begin
				t_sel = TNom;
			end else begin
				t_sel = TMin;
			end
		end else if (t_div < TMin) begin
			t_sel = TMin;
		end else if (t_div > TMax) begin
			t_sel = TMax;
		end else begin
			t_sel = t_div;
		end
		t_new = t_sel[tci_pkg::TicksW-1:0];
	end

	tci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_mag),
		.divisor  (d_abs[tci_pkg::DivW-1:0]),
		.busy     (div_busy),
		.quotient (q_mag)
	);

	// phase update
	always_comb begin
		ew_relay  = (cfg.wait_cycle_count == '0) && (cfg.relay_seconds != '0);
		n_relay   = relay_q;
		n_led     = led_q;
		n_end     = 1'b0;
		n_cycles  = cycles_q;
		n_ticks   = ticks_q;
		n_seconds = seconds_q;
		n_subtick = subtick_q;
		t_cur     = (ticks_q == '0) ? t_new : ticks_q;
		t_dec     = t_cur - 1'b1;
		c_dec     = cycles_q - 1'b1;
		s_dec     = seconds_q - 1'b1;
		st_inc    = subtick_q + 1'b1;
		if ((!relay_q && cycles_q == '0) || (relay_q && seconds_q == '0)) begin
			n_relay  = ew_relay;
			n_led    = ew_relay;
			n_ticks  = '0;
			n_cycles = cfg.wait_cycle_count;
			if (ew_relay) begin
				n_seconds = cfg.relay_seconds;
				n_subtick = '0;
			end
		end else if (!relay_q) begin
			n_ticks = t_dec;
			if (t_dec == '0) begin
				n_end    = 1'b1;
				n_led    = ~led_q;
				n_cycles = c_dec;
				if (c_dec == '0) begin
					if (cfg.relay_seconds != '0) begin
						n_relay   = 1'b1;
						n_led     = 1'b1;
						n_seconds = cfg.relay_seconds;
						n_subtick = '0;
					end else begin
						n_relay  = 1'b0;
						n_led    = 1'b0;
						n_ticks  = '0;
						n_cycles = cfg.wait_cycle_count;
					end
				end
			end
		end else begin
			if (st_inc >= SubLimit) begin
				n_subtick = '0;
				n_seconds = s_dec;
				if (s_dec == '0) begin
					n_relay  = ew_relay;
					n_led    = ew_relay;
					n_ticks  = '0;
					n_cycles = cfg.wait_cycle_count;
					if (ew_relay) begin
						n_seconds = cfg.relay_seconds;
					end
				end
			end else begin
				n_subtick = st_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= 1'b0;
			led_q       <= 1'b0;
			cycles_q    <= tci_pkg::WAIT_CYCLE_COUNT_RST;
			ticks_q     <= '0;
			seconds_q   <= '0;
			subtick_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				relay_q   <= n_relay;
				led_q     <= n_led;
				cycles_q  <= n_cycles;
				ticks_q   <= n_ticks;
				seconds_q <= n_seconds;
				subtick_q <= n_subtick;
			end
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= adc_sample;
		end
		if (cmd.apply) begin
			relay_on_q  <= n_relay;
			led_on_q    <= n_led;
			cycle_end_q <= n_end;
		end
	end

	assign stat.need_div = !relay_q && (cycles_q != '0) && (ticks_q == '0) && !d_zero;
	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign relay_on  = relay_on_q;
	assign led_on    = led_on_q;
	assign cycle_end = cycle_end_q;

	a_relay_led: assert property (@(posedge clk) disable iff (!arst_n)
		relay_q |-> led_q)
		else $error("relay phase with led off");

	a_ticks_range: assert property (@(posedge clk) disable iff (!arst_n)
		ticks_q < tci_pkg::TicksW'(tci_pkg::MaxTicks))
		else $error("tick count out of range");

	a_subtick_range: assert property (@(posedge clk) disable iff (!arst_n)
		subtick_q < SubLimit)
		else $error("subtick count out of range");

endmodule

>>> rtl/core/tci_ctrl.sv
// ----------------------------------------------------------------------------
// tci_ctrl: timer controller
// Sequences one beat through capture, optional division and state update.
// ----------------------------------------------------------------------------
module tci_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tci_pkg::dp_stat_t   stat,
	output tci_pkg::dp_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PREP  = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_APPLY = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;

	assign in_ready      = (state_q == S_IDLE);
	assign cmd.capture   = in_valid && in_ready;
	assign cmd.div_start = (state_q == S_PREP) && stat.need_div;
	assign cmd.apply     = (state_q == S_APPLY) && stat.out_free;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) begin
					state_n = S_PREP;
				end
			end
			S_PREP: begin
				state_n = stat.need_div ? S_DIV : S_APPLY;
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					state_n = S_APPLY;
				end
			end
			S_APPLY: begin
				if (stat.out_free) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> stat.div_busy)
		else $error("divider did not start");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.div_busy)
		else $error("divider busy while idle");

endmodule

>>> rtl/core/temp_compensated_interval_timer_top.sv
// ----------------------------------------------------------------------------
// temp_compensated_interval_timer_top: temperature-scaled interval timer
// One beat per tick; wait cycles scaled by the thermistor sample, then a
// relay phase of whole seconds.
// ----------------------------------------------------------------------------
// sequence: capture in idle, then prep, then div while the 15-step divider
// runs when a new wait cycle starts, then apply, which registers the result
// once the output is free; the next beat is taken only after apply
// reset: asynchronous; state registers take their defaults, wait phase with
// relay and led off; sample, output and divider data registers are not reset
module temp_compensated_interval_timer_top #(
	parameter int TICKS_PER_SECOND = tci_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tci_pkg::AddrW-1:0]     paddr,
	input  logic [tci_pkg::DataW-1:0]     pwdata,
	output logic [tci_pkg::DataW-1:0]     prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tci_pkg::SampleW-1:0]   adc_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          relay_on,
	output logic                          led_on,
	output logic                          cycle_end
);

	tci_pkg::cfg_t      cfg;
	tci_pkg::dp_cmd_t   cmd;
	tci_pkg::dp_stat_t  stat;

	tci_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tci_dp #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.adc_sample (adc_sample),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.relay_on   (relay_on),
		.led_on     (led_on),
		.cycle_end  (cycle_end)
	);

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the temperature-scaled interval timer
// Feeds thermistor samples as tick beats with random gaps and back-pressure,
// reprograms thresholds and phase lengths over APB between bursts with
// read-back, and checks every result beat against a tick-level prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int TicksPerSecond = tci_pkg::TICKS_PER_SECOND_DEF;
	localparam int IdleLimit      = 2000;
	localparam int HoldCycles     = 400;
	localparam int HoldAfter      = 500;
	localparam int CalmFrom       = 700;
	localparam int CalmTo         = 900;
	localparam int NumPhases      = 14;
	localparam int PhaseItems     = 74;

	typedef struct packed {
		logic relay;
		logic led;
		logic cycle_end;
	} timer_out_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         psel       = 1'b0;
	logic                         penable    = 1'b0;
	logic                         pwrite     = 1'b0;
	logic [tci_pkg::AddrW-1:0]    paddr      = '0;
	logic [tci_pkg::DataW-1:0]    pwdata     = '0;
	logic [tci_pkg::DataW-1:0]    prdata;
	logic                         pready;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic [tci_pkg::SampleW-1:0]  adc_sample = '0;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic                         relay_on;
	logic                         led_on;
	logic                         cycle_end;

	logic [tci_pkg::SampleW-1:0]  sample_queue[$];
	timer_out_t                   timer_out_q[$];
	int                           errors       = 0;
	int                           samples_sent = 0;
	int                           hold_left    = 0;
	logic                         hold_done    = 1'b0;
	int                           idle_cycles  = 0;
	logic                         calm;

	tci_pkg::cfg_t                regs_shadow;
	logic                         relay_phase;
	logic [tci_pkg::CyclesW-1:0]  cycles_left;
	logic [tci_pkg::TicksW-1:0]   ticks_left;
	logic                         led_state;
	logic [tci_pkg::SecondsW-1:0] seconds_left;
	logic [6:0]                   subtick;

	assign calm = (samples_sent >= CalmFrom) && (samples_sent < CalmTo);

	temp_compensated_interval_timer_top #(
		.TICKS_PER_SECOND(TicksPerSecond)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.adc_sample(adc_sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.relay_on  (relay_on),
		.led_on    (led_on),
		.cycle_end (cycle_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [tci_pkg::TicksW-1:0] scaled_cycle_ticks(
			input logic [tci_pkg::SampleW-1:0] sample);
		int s;
		int lo;
		int mid;
		int hi;
		int v;
		int d;
		int t;
		s = sample;
		lo = regs_shadow.temp_low;
		mid = regs_shadow.temp_mid;
		hi = regs_shadow.temp_high;
		if (s < lo)
			s = lo;
		else if (s > hi)
			s = hi;
		v = s - mid;
		if (v >= 0) begin
			d = hi - mid;
			if (d == 0)
				t = (v == 0) ? tci_pkg::NominalTicks : tci_pkg::MinTicks;
			else
				t = tci_pkg::NominalTicks - (v * tci_pkg::FastGain) / d;
		end else begin
			d = mid - lo;
			if (d == 0)
				t = tci_pkg::MaxTicks;
			else
				t = tci_pkg::NominalTicks - (v * tci_pkg::SlowGain) / d;
		end
		if (t < tci_pkg::MinTicks)
			t = tci_pkg::MinTicks;
		if (t > tci_pkg::MaxTicks)
			t = tci_pkg::MaxTicks;
		return t[tci_pkg::TicksW-1:0];
	endfunction

	function automatic void start_relay_phase();
		relay_phase = 1'b1;
		led_state = 1'b1;
		seconds_left = regs_shadow.relay_seconds;
		subtick = '0;
	endfunction

	function automatic void start_wait_phase();
		relay_phase = 1'b0;
		led_state = 1'b0;
		ticks_left = '0;
		cycles_left = regs_shadow.wait_cycle_count;
		if (cycles_left == 0 && regs_shadow.relay_seconds != 0)
			start_relay_phase();
	endfunction

	function automatic void advance_tick(input logic [tci_pkg::SampleW-1:0] sample);
		timer_out_t res;
		res.cycle_end = 1'b0;
		if (!relay_phase && cycles_left == 0) begin
			start_wait_phase();
		end else if (relay_phase && seconds_left == 0) begin
			start_wait_phase();
		end else if (!relay_phase) begin
			if (ticks_left == 0)
				ticks_left = scaled_cycle_ticks(sample);
			ticks_left = ticks_left - 1'b1;
			if (ticks_left == 0) begin
				res.cycle_end = 1'b1;
				led_state = ~led_state;
				cycles_left = cycles_left - 1'b1;
				if (cycles_left == 0) begin
					if (regs_shadow.relay_seconds != 0)
						start_relay_phase();
					else
						start_wait_phase();
				end
			end
		end else begin
			subtick = subtick + 1'b1;
			if (subtick >= TicksPerSecond) begin
				subtick = '0;
				seconds_left = seconds_left - 1'b1;
				if (seconds_left == 0)
					start_wait_phase();
			end
		end
		res.relay = relay_phase;
		res.led = led_state;
		timer_out_q.push_back(res);
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [tci_pkg::DataW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= tci_pkg::AddrW'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tci_pkg::REG_TEMP_LOW:
				regs_shadow.temp_low = value[tci_pkg::SampleW-1:0];
			tci_pkg::REG_TEMP_MID:
				regs_shadow.temp_mid = value[tci_pkg::SampleW-1:0];
			tci_pkg::REG_TEMP_HIGH:
				regs_shadow.temp_high = value[tci_pkg::SampleW-1:0];
			tci_pkg::REG_WAIT_CYCLE_COUNT:
				regs_shadow.wait_cycle_count = value[tci_pkg::CyclesW-1:0];
			tci_pkg::REG_RELAY_SECONDS:
				regs_shadow.relay_seconds = value[tci_pkg::SecondsW-1:0];
			default: ;
		endcase
	endtask

	task automatic check_reg(input logic [2:0] idx, input logic [tci_pkg::DataW-1:0] mask,
			input logic [tci_pkg::DataW-1:0] want);
		logic [tci_pkg::DataW-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= tci_pkg::AddrW'(idx) << 2;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata & mask;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			$display("%0t: register %0d read back: expected %0h, actual %0h",
				$time, idx, want, got);
			errors++;
		end
	endtask

	task automatic program_timer(input logic [tci_pkg::SampleW-1:0] lo,
			input logic [tci_pkg::SampleW-1:0] mid,
			input logic [tci_pkg::SampleW-1:0] hi, input logic [tci_pkg::CyclesW-1:0] wcc,
			input logic [tci_pkg::SecondsW-1:0] rsec);
		write_reg(tci_pkg::REG_TEMP_LOW, tci_pkg::DataW'(lo));
		write_reg(tci_pkg::REG_TEMP_MID, tci_pkg::DataW'(mid));
		write_reg(tci_pkg::REG_TEMP_HIGH, tci_pkg::DataW'(hi));
		write_reg(tci_pkg::REG_WAIT_CYCLE_COUNT, tci_pkg::DataW'(wcc));
		write_reg(tci_pkg::REG_RELAY_SECONDS, tci_pkg::DataW'(rsec));
		check_reg(tci_pkg::REG_TEMP_LOW, 32'hFF, tci_pkg::DataW'(lo));
		check_reg(tci_pkg::REG_TEMP_MID, 32'hFF, tci_pkg::DataW'(mid));
		check_reg(tci_pkg::REG_TEMP_HIGH, 32'hFF, tci_pkg::DataW'(hi));
		check_reg(tci_pkg::REG_WAIT_CYCLE_COUNT, 32'hFF_FFFF, tci_pkg::DataW'(wcc));
		check_reg(tci_pkg::REG_RELAY_SECONDS, 32'hFFFF, tci_pkg::DataW'(rsec));
	endtask

	// checked on the falling edge so every update of the rising edge has settled
	task automatic drain_results();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || in_valid || timer_out_q.size() != 0);
	endtask

	// sample driver, predicts each beat as it is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				advance_tick(adc_sample);
				samples_sent <= samples_sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
					in_valid <= 1'b1;
					adc_sample <= sample_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off while samples are still queued
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && samples_sent >= HoldAfter && sample_queue.size() > 20) begin
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_monitor
		timer_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (timer_out_q.size() == 0) begin
					$display("%0t: unexpected beat: expected none, actual relay %0b led %0b end %0b",
						$time, relay_on, led_on, cycle_end);
					errors++;
				end else begin
					want = timer_out_q.pop_front();
					if (relay_on !== want.relay) begin
						$display("%0t: relay_on: expected %0b, actual %0b", $time, want.relay, relay_on);
						errors++;
					end
					if (led_on !== want.led) begin
						$display("%0t: led_on: expected %0b, actual %0b", $time, want.led, led_on);
						errors++;
					end
					if (cycle_end !== want.cycle_end) begin
						$display("%0t: cycle_end: expected %0b, actual %0b",
							$time, want.cycle_end, cycle_end);
						errors++;
					end
				end
			end
			out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 10);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_ready) && !(out_valid && out_ready) && !psel) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("end of test: mismatches");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	initial begin
		int p;
		int n;
		logic [tci_pkg::SampleW-1:0] lo;
		logic [tci_pkg::SampleW-1:0] mid;
		logic [tci_pkg::SampleW-1:0] hi;
		logic [tci_pkg::CyclesW-1:0] wcc;
		logic [tci_pkg::SecondsW-1:0] rsec;
		logic [tci_pkg::SampleW-1:0] smp;

		regs_shadow.temp_low = tci_pkg::TEMP_LOW_RST;
		regs_shadow.temp_mid = tci_pkg::TEMP_MID_RST;
		regs_shadow.temp_high = tci_pkg::TEMP_HIGH_RST;
		regs_shadow.wait_cycle_count = tci_pkg::WAIT_CYCLE_COUNT_RST;
		regs_shadow.relay_seconds = tci_pkg::RELAY_SECONDS_RST;
		relay_phase = 1'b0;
		cycles_left = tci_pkg::WAIT_CYCLE_COUNT_RST;
		ticks_left = '0;
		led_state = 1'b0;
		seconds_left = '0;
		subtick = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: fast cycle first, then field extremes and threshold edges
		sample_queue.push_back(8'd255);
		sample_queue.push_back(8'd0);
		sample_queue.push_back(8'h55);
		sample_queue.push_back(8'hAA);
		sample_queue.push_back(8'd84);
		sample_queue.push_back(8'd83);
		sample_queue.push_back(8'd107);
		sample_queue.push_back(8'd108);
		sample_queue.push_back(8'd141);
		sample_queue.push_back(8'd142);
		sample_queue.push_back(8'h0F);
		sample_queue.push_back(8'hF0);
		drain_results();

		for (p = 0; p < NumPhases; p++) begin
			wcc = ($urandom_range(3) == 0) ? '0 : tci_pkg::CyclesW'($urandom);
			rsec = ($urandom_range(3) == 0) ? '0 : tci_pkg::SecondsW'($urandom);
			case (p)
				0: begin lo = 8'd0;   mid = 8'd0;   hi = 8'd0;   wcc = '0;  rsec = '0; end
				1: begin lo = 8'd0;   mid = 8'd128; hi = 8'd255; wcc = '1;  rsec = '1; end
				2: begin lo = 8'd200; mid = 8'd100; hi = 8'd100; end
				3: begin lo = 8'd100; mid = 8'd100; hi = 8'd50;  end
				4: begin lo = 8'd250; mid = 8'd200; hi = 8'd100; end
				5: begin lo = 8'd255; mid = 8'd255; hi = 8'd255; end
				6: begin lo = 8'd0;   mid = 8'd255; hi = 8'd255; end
				default: begin
					lo = tci_pkg::SampleW'($urandom);
					mid = tci_pkg::SampleW'($urandom);
					hi = tci_pkg::SampleW'($urandom);
					if (p % 2 == 0) begin
						if (lo > mid) {lo, mid} = {mid, lo};
						if (mid > hi) {mid, hi} = {hi, mid};
						if (lo > mid) {lo, mid} = {mid, lo};
					end
				end
			endcase
			program_timer(lo, mid, hi, wcc, rsec);

			for (n = 0; n < PhaseItems; n++) begin
				case ($urandom_range(9))
					0: smp = lo + tci_pkg::SampleW'($urandom_range(2)) - 8'd1;
					1: smp = mid + tci_pkg::SampleW'($urandom_range(2)) - 8'd1;
					2: smp = hi + tci_pkg::SampleW'($urandom_range(2)) - 8'd1;
					3: smp = $urandom_range(1) ? 8'd255 : 8'd0;
					default: smp = tci_pkg::SampleW'($urandom_range(255));
				endcase
				sample_queue.push_back(smp);
			end
			drain_results();
		end

		repeat (25) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
